### hdl/kms_pkg.sv
package kms_pkg;

    localparam int ROWS_DEF = 5;
    localparam int COLS_DEF = 14;

    localparam int MAP_ROWS = 5;
    localparam int MAP_COLS = 14;
    localparam int MAP_SIZE = MAP_ROWS * MAP_COLS;

    localparam int ROW_W  = 3;
    localparam int COL_FIELD_W = 14;
    localparam int COL_IDX_W = 4;
    localparam int CODE_W = 8;
    localparam int MAP_IDX_W = 7;

    localparam logic [CODE_W-1:0] FN_CODE = 8'hF0;

    localparam logic [CODE_W-1:0] KEYMAP_BASE [MAP_SIZE] = '{
        8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
        8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A,
        8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
        8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31,
        8'hE0, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B,
        8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h00, 8'h28,
        8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11,
        8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h00, 8'hE5,
        8'hF0, 8'hE3, 8'hE2, 8'h00, 8'h00, 8'h2C, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h50, 8'h51, 8'h52, 8'h4F
    };

    localparam logic [CODE_W-1:0] KEYMAP_FN [MAP_SIZE] = '{
        8'h29, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
        8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h4C,
        8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
        8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31,
        8'hE0, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B,
        8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h00, 8'h28,
        8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11,
        8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h00, 8'hE5,
        8'hF0, 8'hE3, 8'hE2, 8'h00, 8'h00, 8'h2C, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h50, 8'h51, 8'h52, 8'h4F
    };

    // positions outside the table read as zero
    function automatic logic [CODE_W-1:0] keymap_code(
        input logic                 layer,
        input logic [ROW_W-1:0]     row,
        input logic [COL_IDX_W-1:0] col
    );
        logic [MAP_IDX_W-1:0] idx;
        logic [CODE_W-1:0]    code;
        idx = MAP_IDX_W'(row) * MAP_IDX_W'(MAP_COLS) + MAP_IDX_W'(col);
        if (int'(row) >= MAP_ROWS || int'(col) >= MAP_COLS) begin
            code = '0;
        end else if (layer) begin
            code = KEYMAP_FN[idx];
        end else begin
            code = KEYMAP_BASE[idx];
        end
        return code;
    endfunction

    function automatic logic [COL_FIELD_W-1:0] fn_mask(
        input logic             layer,
        input logic [ROW_W-1:0] row
    );
        logic [COL_FIELD_W-1:0] mask;
        for (int c = 0; c < COL_FIELD_W; c++) begin
            mask[c] = (keymap_code(layer, row, COL_IDX_W'(c)) == FN_CODE);
        end
        return mask;
    endfunction

endpackage

### hdl/key_matrix_scan_layer_lookup.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-----------------------------------------
// row in   | input     | i_valid / o_ready  | i_row_index, i_column_bits, i_fn_probe
// key out  | output    | o_valid / i_ready  | o_keycode, o_key_found
//
// one row transfer per cycle unless the row side stalls; the keymap rom read
// is registered, then the result of a frame's last row goes to the output register
// synchronous active low reset selects the base layer and clears the frame
// the row side stalls only while a last row waits on a full output register
// rows at or beyond ROWS are taken and dropped
module key_matrix_scan_layer_lookup
    import kms_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [ROW_W-1:0]       i_row_index,
    input  logic [COL_FIELD_W-1:0] i_column_bits,
    input  logic                   i_fn_probe,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [CODE_W-1:0]      o_keycode,
    output logic                   o_key_found
);

    localparam int NCOL = (COLS < COL_FIELD_W) ? COLS : COL_FIELD_W;

    logic                   r_layer;
    logic                   r_hit;
    logic [CODE_W-1:0]      r_held;
    logic                   r_b_valid;
    logic                   r_b_open;
    logic                   r_b_last;
    logic                   r_b_found;
    logic [CODE_W-1:0]      r_code;
    logic                   r_out_valid;
    logic [CODE_W-1:0]      r_out_code;
    logic                   r_out_found;

    logic                   n_hit;
    logic [CODE_W-1:0]      n_held;

    logic                   accept_in;
    logic                   row_ok;
    logic                   row_first;
    logic                   row_last;
    logic                   layer_sel;
    logic [COL_FIELD_W-1:0] col_mask;
    logic [COL_FIELD_W-1:0] cand;
    logic                   found;
    logic [COL_IDX_W-1:0]   first_col;
    logic                   b_advance;

    always_comb begin
        for (int c = 0; c < COL_FIELD_W; c++) begin
            col_mask[c] = (c < NCOL);
        end
    end

    assign row_ok    = int'(i_row_index) < ROWS;
    assign row_first = (i_row_index == '0);
    assign row_last  = (int'(i_row_index) == ROWS - 1);
    assign layer_sel = row_first ? i_fn_probe : r_layer;
    assign cand      = i_column_bits & col_mask & ~fn_mask(layer_sel, i_row_index);
    assign found     = |cand;

    // lowest pressed column wins
    always_comb begin
        first_col = '0;
        for (int c = COL_FIELD_W - 1; c >= 0; c--) begin
            if (cand[c]) begin
                first_col = COL_IDX_W'(c);
            end
        end
    end

    assign b_advance = r_b_valid && (!r_b_last || !r_out_valid || i_ready);
    assign o_ready   = !r_b_valid || b_advance;
    assign accept_in = i_valid && o_ready;

    // frame search state after this row
    always_comb begin
        if (r_b_open) begin
            n_hit  = r_b_found;
            n_held = r_b_found ? r_code : '0;
        end else if (!r_hit && r_b_found) begin
            n_hit  = 1'b1;
            n_held = r_code;
        end else begin
            n_hit  = r_hit;
            n_held = r_held;
        end
    end

    // keymap rom, registered read
    always_ff @(posedge i_clk) begin
        if (accept_in && row_ok) begin
            r_code    <= keymap_code(layer_sel, i_row_index, first_col);
            r_b_open  <= row_first;
            r_b_last  <= row_last;
            r_b_found <= found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer     <= 1'b0;
            r_hit       <= 1'b0;
            r_held      <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in && row_ok && row_first) begin
                r_layer <= i_fn_probe;
            end
            if (o_ready) begin
                r_b_valid <= accept_in && row_ok;
            end
            if (b_advance) begin
                r_hit  <= n_hit;
                r_held <= n_held;
            end
            if (b_advance && r_b_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_advance && r_b_last) begin
            r_out_code  <= n_held;
            r_out_found <= n_hit;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_keycode   = r_out_code;
    assign o_key_found = r_out_found;

    // a last row never leaves the pipe while an untaken result sits ahead of it
    a_last_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_last && r_out_valid && !i_ready |=> r_b_valid && r_b_last)
        else $error("last row lost while output stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_b_valid && r_b_last && r_out_valid && !i_ready)
        else $error("row side stalled without a waiting result");

    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_hit |-> r_held == '0)
        else $error("held code set without a hit");

    a_out_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_key_found |-> o_keycode == '0)
        else $error("keycode without key found");

endmodule

### dv/tb_key_matrix_scan_layer_lookup.sv
`timescale 1ns / 100ps

module tb_key_matrix_scan_layer_lookup
    import kms_pkg::*;
();

    localparam int SCAN_ROWS  = 5;
    localparam int SCAN_COLS  = 14;
    localparam int ROW_ITEMS  = 1400;
    localparam int CYCLE_CAP  = 400000;
    localparam int LONG_HOLD  = 400;
    localparam logic [CODE_W-1:0] FN_KEY = 8'hF0;

    localparam logic [CODE_W-1:0] BASE_MAP [SCAN_ROWS][SCAN_COLS] = '{
        '{8'h35, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
          8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A},
        '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C,
          8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30, 8'h31},
        '{8'hE0, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B,
          8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h00, 8'h28},
        '{8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11,
          8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h00, 8'hE5},
        '{8'hF0, 8'hE3, 8'hE2, 8'h00, 8'h00, 8'h2C, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h50, 8'h51, 8'h52, 8'h4F}
    };

    // only the top row differs on the fn layer
    localparam logic [CODE_W-1:0] FN_TOP_ROW [SCAN_COLS] = '{
        8'h29, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
        8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h4C
    };

    class key_frame_scoreboard;
        bit                fn_layer;
        logic [CODE_W-1:0] held_key;
        bit                key_hit;
        logic [CODE_W:0]   key_q[$];
        int                faults;

        function new();
            fn_layer = 1'b0;
            held_key = '0;
            key_hit  = 1'b0;
            faults   = 0;
        endfunction

        function int pending();
            return key_q.size();
        endfunction

        function void note_row(input logic [ROW_W-1:0] row,
                               input logic [COL_FIELD_W-1:0] bits,
                               input logic probe);
            logic [CODE_W-1:0] code;
            if (int'(row) >= SCAN_ROWS) return;
            if (row == '0) begin
                fn_layer = probe;
                held_key = '0;
                key_hit  = 1'b0;
            end
            if (!key_hit) begin
                for (int c = 0; c < SCAN_COLS && c < COL_FIELD_W; c++) begin
                    code = (fn_layer && row == '0) ? FN_TOP_ROW[c] : BASE_MAP[row][c];
                    if (bits[c] && code != FN_KEY) begin
                        held_key = code;
                        key_hit  = 1'b1;
                        break;
                    end
                end
            end
            if (int'(row) == SCAN_ROWS - 1) key_q.push_back({key_hit, held_key});
        endfunction

        function void check_key(input logic [CODE_W-1:0] code, input logic found);
            logic [CODE_W:0] want;
            if (key_q.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected key result: code %02h found %0b", code, found);
                return;
            end
            want = key_q.pop_front();
            if (code !== want[CODE_W-1:0] || found !== want[CODE_W]) begin
                faults++;
                if (faults <= 10)
                    $display({"key result mismatch: expected code %02h found %0b, ",
                              "got code %02h found %0b"},
                             want[CODE_W-1:0], want[CODE_W], code, found);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [ROW_W-1:0]       i_row_index;
    logic [COL_FIELD_W-1:0] i_column_bits;
    logic                   i_fn_probe;
    logic                   o_valid;
    logic                   i_ready;
    logic [CODE_W-1:0]      o_keycode;
    logic                   o_key_found;

    key_frame_scoreboard frames;
    int  cycles;
    int  keys_taken;
    int  rows_sent;
    bit  burst_mode;
    bit  long_hold_done;

    key_matrix_scan_layer_lookup #(
        .ROWS(SCAN_ROWS),
        .COLS(SCAN_COLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_row_index   (i_row_index),
        .i_column_bits (i_column_bits),
        .i_fn_probe    (i_fn_probe),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_keycode     (o_keycode),
        .o_key_found   (o_key_found)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("tb_key_matrix_scan_layer_lookup: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            frames.check_key(o_keycode, o_key_found);
            keys_taken <= keys_taken + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COL_FIELD_W-1:0] pick_bits();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return COL_FIELD_W'(1) << $urandom_range(0, COL_FIELD_W - 1);
        if (r < 45) return (COL_FIELD_W'(1) << $urandom_range(0, COL_FIELD_W - 1)) |
                           (COL_FIELD_W'(1) << $urandom_range(0, COL_FIELD_W - 1));
        if (r < 70) return COL_FIELD_W'($urandom_range(0, 16383));
        if (r < 80) return '1;
        if (r < 90) return COL_FIELD_W'(1) | (COL_FIELD_W'($urandom_range(0, 1)) << 1);
        return '0;
    endfunction

    // receiver: random ready pattern, one long hold once results are flowing
    initial begin
        int run;
        int low;
        long_hold_done = 1'b0;
        forever begin
            i_ready <= 1'b1;
            run = $urandom_range(1, 30);
            repeat (run) @(posedge i_clk);
            low = pick_gap();
            if (!long_hold_done && keys_taken >= 60) begin
                long_hold_done = 1'b1;
                low = LONG_HOLD;
            end
            if (low > 0) begin
                i_ready <= 1'b0;
                repeat (low) @(posedge i_clk);
            end
        end
    end

    task automatic send_row(input logic [ROW_W-1:0] row,
                            input logic [COL_FIELD_W-1:0] bits,
                            input logic probe);
        int gap;
        i_valid       <= 1'b1;
        i_row_index   <= row;
        i_column_bits <= bits;
        i_fn_probe    <= probe;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        frames.note_row(row, bits, probe);
        if (int'(row) < SCAN_ROWS) rows_sent++;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input logic probe, input logic [COL_FIELD_W-1:0] b0,
                              input logic [COL_FIELD_W-1:0] b1,
                              input logic [COL_FIELD_W-1:0] b2,
                              input logic [COL_FIELD_W-1:0] b3,
                              input logic [COL_FIELD_W-1:0] b4);
        send_row(3'd0, b0, probe);
        send_row(3'd1, b1, ~probe);
        send_row(3'd2, b2, probe);
        send_row(3'd3, b3, ~probe);
        send_row(3'd4, b4, probe);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (frames.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int  kind;
        int  first_row;
        int  n;
        bit  probe;
        bit  mid_drain_done;
        frames         = new();
        cycles         = 0;
        keys_taken     = 0;
        rows_sent      = 0;
        burst_mode     = 1'b0;
        mid_drain_done = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_row_index   <= '0;
        i_column_bits <= '0;
        i_fn_probe    <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // rows before any frame start, unmapped hit kept through the last row
        send_row(3'd3, 14'h0800, 1'b1);
        send_row(3'd4, 14'h0000, 1'b0);
        // out of range rows are dropped
        send_row(3'd5, 14'h3FFF, 1'b1);
        send_row(3'd7, 14'h3FFF, 1'b0);
        send_row(3'd6, 14'h1555, 1'b1);
        send_frame(1'b1, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        send_frame(1'b0, 14'h0000, 14'h0000, 14'h1000, 14'h3FFF, 14'h3FFF);
        // fn position alone finds nothing, then the scan carries on past it
        send_frame(1'b0, 14'h0000, 14'h0000, 14'h0000, 14'h0000, 14'h0001);
        send_row(3'd0, 14'h0000, 1'b1);
        send_row(3'd4, 14'h0003, 1'b0);
        send_row(3'd4, 14'h2000, 1'b1);
        send_frame(1'b0, 14'h2000, 14'h0000, 14'h0000, 14'h0000, 14'h0000);
        wait_drained();

        rows_sent = 0;
        while (rows_sent < ROW_ITEMS) begin
            burst_mode = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            probe = 1'($urandom_range(0, 1));
            if (kind < 85) begin
                first_row = $urandom_range(0, SCAN_ROWS);
                for (int r = 0; r < SCAN_ROWS; r++)
                    send_row(ROW_W'(r), (r < first_row) ? '0 : pick_bits(),
                             (r == 0) ? probe : 1'($urandom_range(0, 1)));
            end else if (kind < 93) begin
                n = $urandom_range(1, 6);
                repeat (n) send_row(ROW_W'($urandom_range(0, SCAN_ROWS - 1)), pick_bits(),
                                    1'($urandom_range(0, 1)));
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send_row(ROW_W'($urandom_range(0, 7)),
                                    COL_FIELD_W'($urandom_range(0, 16383)),
                                    1'($urandom_range(0, 1)));
            end
            if (!mid_drain_done && rows_sent >= ROW_ITEMS / 2) begin
                mid_drain_done = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (frames.faults == 0) begin
            $display("tb_key_matrix_scan_layer_lookup: done, clean");
        end else begin
            $display("tb_key_matrix_scan_layer_lookup: done, errors");
        end
        $finish;
    end

endmodule

### files.f
hdl/kms_pkg.sv
hdl/key_matrix_scan_layer_lookup.sv
dv/tb_key_matrix_scan_layer_lookup.sv
